// ===== src/mtbd_pkg.sv =====
// Shared types, constants and helper functions for the material texel decoder.
// No dependencies; every other file imports this package.
package mtbd_pkg;

    // Coefficient fields: low COEF_BITS bits of each 12-bit field, two's complement
    localparam int COEF_BITS    = 12;
    localparam int FIELD_STRIDE = 12;

    // Configuration port
    localparam int NUM_REGS   = 8;
    localparam int REG_SEL_W  = $clog2(NUM_REGS);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 60;
    localparam int OCC_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_RED   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NX    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NY    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROUGH = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_METAL = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OCCL  = 4'd7;

    // Channel lanes, same order as the registers
    localparam int NUM_CH   = 8;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_NX    = 3;
    localparam int CH_NY    = 4;
    localparam int CH_ROUGH = 5;
    localparam int CH_METAL = 6;
    localparam int CH_OCCL  = 7;

    // Terms per lane: x, y, z, w weights then the offset
    localparam int NUM_TERMS = 4;
    localparam int NUM_FLD   = NUM_TERMS + 1;
    localparam int OFS_FLD   = NUM_TERMS;
    localparam int TERM_X    = 0;
    localparam int TERM_Y    = 1;
    localparam int TERM_Z    = 2;
    localparam int TERM_W    = 3;

    // Datapath widths
    localparam int D_W    = 9;                  // 2p - 255
    localparam int PROD_W = D_W + COEF_BITS;
    localparam int SUM_W  = PROD_W + 3;         // five terms
    localparam int NZ_W   = SUM_W + 2;          // 2S - 65280
    localparam int ABS_W  = NZ_W - 1;
    localparam int SQ_W   = 2 * ABS_W;
    localparam int Q_W    = SQ_W + 1;

    // Square root unit: 32-bit radicand, a few result bits per stage
    localparam int RAD_W           = 32;
    localparam int ROOT_W          = RAD_W / 2;
    localparam int REM_W           = ROOT_W + 2;
    localparam int STEPS_PER_STAGE = 4;
    localparam int SQRT_STAGES     = ROOT_W / STEPS_PER_STAGE;

    // Normal z constants
    localparam int              NZ_NUM_W     = 18;
    localparam int              NZ_LIM       = 65280;
    localparam longint unsigned NZ_LIM_SQ    = 64'd4261478400;
    localparam int              NZ_TOP       = 130816;
    localparam int              NZ_CLAMP_NUM = NZ_TOP - NZ_LIM;

    // Pipeline: products, sums, bytes/abs, squares, radicand, sqrt stages, output
    localparam int LAT       = 5 + SQRT_STAGES + 1;
    localparam int BYTE_PIPE = LAT - 2;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef coef_t [NUM_FLD-1:0]         chan_coef_t;
    typedef chan_coef_t [NUM_CH-1:0]     coef_set_t;

    typedef logic signed [D_W-1:0]       dcoef_t;
    typedef dcoef_t [NUM_TERMS-1:0]      d_vec_t;

    typedef logic [7:0]                  byte_t;
    typedef byte_t [NUM_CH-1:0]          chan_bytes_t;

    typedef struct packed {
        logic [7:0] chan_x;
        logic [7:0] chan_y;
        logic [7:0] chan_z;
        logic [7:0] chan_w;
    } texel_t;

    typedef struct packed {
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
        logic [7:0] norm_out_x;
        logic [7:0] norm_out_y;
        logic [7:0] norm_out_z;
        logic [7:0] roughness_out;
        logic [7:0] metalness_out;
        logic [7:0] occlusion_out;
    } result_t;

    // One square root pipeline slot
    typedef struct packed {
        logic              clamp;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    // Byte p to signed coefficient 2p - 255
    function automatic dcoef_t coef_of_byte(input logic [7:0] p);
        logic signed [D_W:0] t;
        begin
            t = $signed({1'b0, p, 1'b0}) - (D_W+1)'(255);
            return t[D_W-1:0];
        end
    endfunction

    // Round S/256 to nearest, ties up, saturate to 0..255
    function automatic byte_t to_byte(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        logic [SUM_W-9:0] q;
        begin
            t = $unsigned(s) + SUM_W'(128);
            q = t[SUM_W-1:8];
            if (s < 0)
                return 8'd0;
            else if (q > (SUM_W-8)'(255))
                return 8'd255;
            else
                return q[7:0];
        end
    endfunction

endpackage

// ===== src/mtbd_cfg.sv =====
// Configuration registers and coefficient field decode.
// Depends on mtbd_pkg.
module mtbd_cfg
    import mtbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output coef_set_t             coefs
);

    logic [CFG_DATA_W-1:0] cfg_reg [NUM_REGS];
    logic [REG_SEL_W-1:0]  sel;
    logic                  hit;

    assign sel = cfg_index[REG_SEL_W-1:0];
    assign hit = cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS));

    // Register write; out-of-range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                cfg_reg[i] <= '0;
        end
        else if (hit)
        begin
            if (cfg_index == REG_OCCL)
                cfg_reg[sel] <= CFG_DATA_W'(cfg_data[OCC_DATA_W-1:0]);
            else
                cfg_reg[sel] <= cfg_data;
        end
    end

    // Field decode; occlusion is remapped onto the x,y,z,w lane layout
    always_comb
    begin
        for (int ch = 0; ch < CH_OCCL; ch++)
        begin
            for (int f = 0; f < NUM_FLD; f++)
                coefs[ch][f] = cfg_reg[ch][FIELD_STRIDE*f +: COEF_BITS];
        end
        coefs[CH_OCCL][TERM_X]  = cfg_reg[CH_OCCL][FIELD_STRIDE*1 +: COEF_BITS];
        coefs[CH_OCCL][TERM_Y]  = cfg_reg[CH_OCCL][FIELD_STRIDE*2 +: COEF_BITS];
        coefs[CH_OCCL][TERM_Z]  = '0;
        coefs[CH_OCCL][TERM_W]  = cfg_reg[CH_OCCL][FIELD_STRIDE*0 +: COEF_BITS];
        coefs[CH_OCCL][OFS_FLD] = cfg_reg[CH_OCCL][FIELD_STRIDE*3 +: COEF_BITS];
    end

endmodule

// ===== src/mtbd_dot.sv =====
// One channel lane: registered products, then registered five-term sum.
// Depends on mtbd_pkg.
module mtbd_dot
    import mtbd_pkg::*;
(
    input  logic                    clk,
    input  d_vec_t                  d,
    input  chan_coef_t              w,
    output logic signed [SUM_W-1:0] sum
);

    logic signed [PROD_W-1:0] prod_reg  [NUM_FLD];
    logic signed [PROD_W-1:0] prod_next [NUM_FLD];
    logic signed [PROD_W-1:0] ofs;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    // Stage 1: d*W per term, 255*offset as shift and subtract
    always_comb
    begin
        for (int i = 0; i < NUM_TERMS; i++)
            prod_next[i] = PROD_W'($signed(d[i])) * PROD_W'($signed(w[i]));
        ofs                = PROD_W'($signed(w[OFS_FLD]));
        prod_next[OFS_FLD] = (ofs <<< 8) - ofs;
    end

    // Stage 2: sum of products
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NUM_FLD; i++)
            sum_next = sum_next + SUM_W'(prod_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_FLD; i++)
            prod_reg[i] <= prod_next[i];
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

// ===== src/mtbd_sqrt_stage.sv =====
// One stage of the digit-by-digit square root: a few result bits, then a register.
// Depends on mtbd_pkg.
module mtbd_sqrt_stage
    import mtbd_pkg::*;
(
    input  logic  clk,
    input  sqrt_t din,
    output sqrt_t dout
);

    sqrt_t            stage_next;
    sqrt_t            stage_reg;
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;

    // Restoring steps; radicand is consumed two bits at a time from the top
    always_comb
    begin
        stage_next = din;
        cur        = '0;
        trial      = '0;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            cur            = {stage_next.rem, stage_next.rad[RAD_W-1 -: 2]};
            trial          = (REM_W+2)'({stage_next.root, 2'b01});
            stage_next.rad = stage_next.rad << 2;
            if (cur >= trial)
            begin
                stage_next.rem  = REM_W'(cur - trial);
                stage_next.root = {stage_next.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                stage_next.rem  = cur[REM_W-1:0];
                stage_next.root = {stage_next.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign dout = stage_reg;

endmodule

// ===== src/mtbd_normz.sv =====
// Normal z path: |2S-65280| per axis, squares, radicand with clamp, pipelined
// square root and final rounding. Depends on mtbd_pkg and mtbd_sqrt_stage.
module mtbd_normz
    import mtbd_pkg::*;
(
    input  logic                    clk,
    input  logic signed [SUM_W-1:0] sum_x,
    input  logic signed [SUM_W-1:0] sum_y,
    output logic [7:0]              norm_z
);

    logic signed [NZ_W-1:0] a_s;
    logic signed [NZ_W-1:0] b_s;
    logic [ABS_W-1:0]       abs_a_reg;
    logic [ABS_W-1:0]       abs_a_next;
    logic [ABS_W-1:0]       abs_b_reg;
    logic [ABS_W-1:0]       abs_b_next;
    logic [SQ_W-1:0]        sq_a_reg;
    logic [SQ_W-1:0]        sq_b_reg;
    logic [Q_W-1:0]         q;
    sqrt_t                  head_reg;
    sqrt_t                  head_next;
    sqrt_t                  chain [SQRT_STAGES+1];
    sqrt_t                  tail;
    logic [NZ_NUM_W-1:0]    num;
    logic [NZ_NUM_W-10:0]   num_hi;
    logic [7:0]             z_reg;
    logic [7:0]             z_next;

    // Normal xy in units of 1/65280, magnitude only
    always_comb
    begin
        a_s        = (NZ_W'(sum_x) <<< 1) - NZ_W'(NZ_LIM);
        b_s        = (NZ_W'(sum_y) <<< 1) - NZ_W'(NZ_LIM);
        abs_a_next = (a_s < 0) ? ABS_W'(-a_s) : ABS_W'(a_s);
        abs_b_next = (b_s < 0) ? ABS_W'(-b_s) : ABS_W'(b_s);
    end

    // Radicand and clamp at length one
    always_comb
    begin
        q               = Q_W'(sq_a_reg) + Q_W'(sq_b_reg);
        head_next.clamp = (q >= Q_W'(NZ_LIM_SQ));
        head_next.rad   = q[RAD_W-1:0];
        head_next.rem   = '0;
        head_next.root  = '0;
    end

    always_ff @(posedge clk)
    begin
        abs_a_reg <= abs_a_next;
        abs_b_reg <= abs_b_next;
        sq_a_reg  <= SQ_W'(abs_a_reg) * SQ_W'(abs_a_reg);
        sq_b_reg  <= SQ_W'(abs_b_reg) * SQ_W'(abs_b_reg);
        head_reg  <= head_next;
        z_reg     <= z_next;
    end

    // Square root stages
    assign chain[0] = head_reg;

    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_sqrt
        mtbd_sqrt_stage u_stage (
            .clk  (clk),
            .din  (chain[s]),
            .dout (chain[s+1])
        );
    end

    // 130816 - ceil(sqrt(q)), divided by 512
    always_comb
    begin
        tail = chain[SQRT_STAGES];
        if (tail.clamp)
            num = NZ_NUM_W'(NZ_CLAMP_NUM);
        else
            num = NZ_NUM_W'(NZ_TOP) - NZ_NUM_W'(tail.root)
                  - NZ_NUM_W'(tail.rem != '0);
        num_hi = num[NZ_NUM_W-1:9];
        z_next = (num_hi > (NZ_NUM_W-9)'(255)) ? 8'd255 : num_hi[7:0];
    end

    assign norm_z = z_reg;

endmodule

// ===== src/material_texture_basis_decode_core.sv =====
// Material texel decoder, top level.
// Depends on mtbd_pkg, mtbd_cfg, mtbd_dot and mtbd_normz.
//
// Usage:
//   Input channel: drive texel and pulse start; an item is taken at each rising
//   edge with start high and busy low. busy stays low, so one texel per cycle
//   can be issued back to back.
//   Result channel: strobe is high for exactly one cycle with the decoded
//   material channels on result. Throughput is one item per cycle. The
//   depth is set by the normal z path: products, sums, absolute values,
//   squares, radicand, a four-stage square root (four result bits per
//   stage) and the output register.
//   The receiver cannot stall; results are only presented, never held.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
//   cfg_index selects one of the eight weight registers, indexes 8 and up are
//   ignored. Write only while no item is in flight.
//   Reset: rst_n clears the weight registers to zero and empties the pipeline;
//   no item in flight at reset is delivered.
module material_texture_basis_decode_core
    import mtbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  texel_t                texel,
    output logic                  strobe,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    coef_set_t               coefs;
    d_vec_t                  d_vec;
    logic signed [SUM_W-1:0] sums [NUM_CH];
    logic [7:0]              norm_z;
    logic [LAT-1:0]          valid_reg;
    logic [LAT-1:0]          valid_next;
    chan_bytes_t             byte_pipe_reg [BYTE_PIPE];
    chan_bytes_t             bytes_next;
    chan_bytes_t             bytes_out;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Weight registers
    mtbd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    // Byte to signed coefficient
    always_comb
    begin
        d_vec[TERM_X] = coef_of_byte(texel.chan_x);
        d_vec[TERM_Y] = coef_of_byte(texel.chan_y);
        d_vec[TERM_Z] = coef_of_byte(texel.chan_z);
        d_vec[TERM_W] = coef_of_byte(texel.chan_w);
    end

    // Channel lanes
    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_lane
        mtbd_dot u_dot (
            .clk (clk),
            .d   (d_vec),
            .w   (coefs[ch]),
            .sum (sums[ch])
        );
    end

    // Normal z path
    mtbd_normz u_normz (
        .clk    (clk),
        .sum_x  (sums[CH_NX]),
        .sum_y  (sums[CH_NY]),
        .norm_z (norm_z)
    );

    // Rounded bytes, delayed to line up with normal z
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
            bytes_next[ch] = to_byte(sums[ch]);
    end

    always_ff @(posedge clk)
    begin
        byte_pipe_reg[0] <= bytes_next;
        for (int i = 1; i < BYTE_PIPE; i++)
            byte_pipe_reg[i] <= byte_pipe_reg[i-1];
    end

    // Valid bits travel with the data
    assign valid_next = {valid_reg[LAT-2:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Result
    assign bytes_out = byte_pipe_reg[BYTE_PIPE-1];
    assign strobe    = valid_reg[LAT-1];

    always_comb
    begin
        result.base_red      = bytes_out[CH_RED];
        result.base_green    = bytes_out[CH_GREEN];
        result.base_blue     = bytes_out[CH_BLUE];
        result.norm_out_x    = bytes_out[CH_NX];
        result.norm_out_y    = bytes_out[CH_NY];
        result.norm_out_z    = norm_z;
        result.roughness_out = bytes_out[CH_ROUGH];
        result.metalness_out = bytes_out[CH_METAL];
        result.occlusion_out = bytes_out[CH_OCCL];
    end

`ifndef SYNTH
    // Every result traces back to an item taken earlier
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start, LAT))
        else $error("result without a matching item");

    // Every accepted item yields a result
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT strobe)
        else $error("accepted item produced no result");

    // Normal z is at least half scale
    a_nz_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> result.norm_out_z[7])
        else $error("normal z below 128");
`endif

endmodule
